FILE: rtl/miller_rabin_witness_test_assert.svh
// assertion macros for the miller-rabin witness test
`ifndef MILLER_RABIN_WITNESS_TEST_ASSERT_SVH
`define MILLER_RABIN_WITNESS_TEST_ASSERT_SVH

// implication checked on every clock edge outside reset
`define MRW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define MRW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/mrw_pkg.sv
// shared types and constants for the miller-rabin witness test
package mrw_pkg;
  localparam int unsigned WIDTH_DEF = 64;
  localparam int unsigned FIELD_W   = 64;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SPLIT,
    ST_POW_MUL,
    ST_POW_SQR,
    ST_POW_NEXT,
    ST_CHECK,
    ST_SQR,
    ST_SQR_CHECK,
    ST_DONE
  } mrw_state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } mrw_mul_ctl_t;
endpackage

FILE: rtl/mrw_if.sv
// valid/ready channel carrying a payload
interface mrw_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/miller_rabin_witness_test.sv
// top level of the miller-rabin witness test
// each modular multiply steps through its multiplier one bit per cycle
// witness reduction is by restoring shift-subtract
// one item at a time; a waiting result holds back only the next result, not the next input transfer
// synchronous active-low reset clears the control state and the composite flag
module miller_rabin_witness_test #(
  parameter int unsigned WIDTH = mrw_pkg::WIDTH_DEF
) (
  input logic clk,
  input logic rst_n,
  mrw_if.sink   in_ch,
  mrw_if.source out_ch
);
  import mrw_pkg::*;
  `include "miller_rabin_witness_test_assert.svh"

  localparam int unsigned CW = $clog2(WIDTH + 1);

  mrw_state_t state_r, state_nxt;
  logic [WIDTH-1:0] n_r, a_r, r_r, acc_r, b_r, top_r;
  logic [WIDTH:0]   rem_r;
  logic [CW-1:0]    s_r, j_r, cnt_r;
  logic             last_r, fail_r, comp_r, out_valid_r, out_data_r;

  logic             mul_start;
  logic [WIDTH-1:0] mul_x, mul_y, mul_p;
  mrw_mul_ctl_t     mul_ctl;
  logic [WIDTH:0]   rem_sh;
  logic             trivial_pass, trivial_fail, out_stall, out_load;

  mrw_mulmod #(.WIDTH(WIDTH)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .x(mul_x), .y(mul_y), .m(n_r),
    .prod(mul_p), .ctl(mul_ctl)
  );

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.data        = out_data_r;
  assign rem_sh = {rem_r[WIDTH-1:0], a_r[WIDTH-1 - cnt_r[CW-1:0]]};

  assign trivial_pass = (n_r == WIDTH'(2)) || (n_r == WIDTH'(3));
  assign trivial_fail = !trivial_pass && (n_r <= WIDTH'(1) || !n_r[0]);
  assign out_stall    = last_r && out_valid_r && !out_ch.ready;
  assign out_load     = (state_r == ST_DONE) && last_r && !out_stall;

  always_comb begin
    state_nxt = state_r;
    mul_start = 1'b0;
    mul_x     = acc_r;
    mul_y     = b_r;
    case (state_r)
      ST_IDLE:   if (in_ch.valid && in_ch.ready) state_nxt = ST_REDUCE;
      ST_REDUCE: begin
        if (trivial_pass || trivial_fail) state_nxt = ST_DONE;
        else if (cnt_r == CW'(WIDTH)) state_nxt = ST_SPLIT;
      end
      ST_SPLIT:  if (r_r[0]) state_nxt = ST_POW_MUL;
      ST_POW_MUL: begin
        if (r_r == '0) state_nxt = ST_CHECK;
        else if (!r_r[0]) state_nxt = ST_POW_SQR;
        else begin
          mul_start = !mul_ctl.busy && !mul_ctl.done;
          if (mul_ctl.done) state_nxt = ST_POW_SQR;
        end
      end
      ST_POW_SQR: begin
        mul_x = b_r;
        mul_start = !mul_ctl.busy && !mul_ctl.done;
        if (mul_ctl.done) state_nxt = ST_POW_MUL;
      end
      ST_CHECK: begin
        if (acc_r == WIDTH'(1) || acc_r == top_r || j_r >= s_r) state_nxt = ST_DONE;
        else state_nxt = ST_SQR;
      end
      ST_SQR: begin
        mul_x = acc_r;
        mul_y = acc_r;
        mul_start = !mul_ctl.busy && !mul_ctl.done;
        if (mul_ctl.done) state_nxt = ST_SQR_CHECK;
      end
      ST_SQR_CHECK: begin
        if (acc_r == WIDTH'(1) || acc_r == top_r || j_r >= s_r) state_nxt = ST_DONE;
        else state_nxt = ST_SQR;
      end
      ST_DONE:   if (!out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // result register, loaded on the last witness and held until its transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
      out_data_r  <= !(comp_r || fail_r);
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comp_r      <= 1'b0;
      fail_r      <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: if (in_ch.valid && in_ch.ready) begin
          n_r    <= in_ch.data.candidate[WIDTH-1:0];
          a_r    <= in_ch.data.witness[WIDTH-1:0];
          last_r <= in_ch.data.last_witness;
          top_r  <= in_ch.data.candidate[WIDTH-1:0] - WIDTH'(1);
          r_r    <= in_ch.data.candidate[WIDTH-1:0] - WIDTH'(1);
          rem_r  <= '0;
          cnt_r  <= '0;
          s_r    <= '0;
          j_r    <= CW'(1);
          acc_r  <= WIDTH'(1);
          fail_r <= 1'b0;
        end
        ST_REDUCE: begin
          if (trivial_pass) begin
            fail_r <= 1'b0;
          end else if (trivial_fail) begin
            fail_r <= 1'b1;
          end else if (cnt_r != CW'(WIDTH)) begin
            rem_r <= (rem_sh >= {1'b0, n_r}) ? rem_sh - {1'b0, n_r} : rem_sh;
            cnt_r <= cnt_r + CW'(1);
          end else b_r <= rem_r[WIDTH-1:0];
        end
        ST_SPLIT: if (!r_r[0]) begin
          r_r <= r_r >> 1;
          s_r <= s_r + CW'(1);
        end
        ST_POW_MUL: if (r_r != '0 && r_r[0] && mul_ctl.done) acc_r <= mul_p;
        ST_POW_SQR: if (mul_ctl.done) begin
          b_r <= mul_p;
          r_r <= r_r >> 1;
        end
        ST_CHECK: if (!(acc_r == WIDTH'(1) || acc_r == top_r || j_r >= s_r))
          fail_r <= 1'b0;
        else
          fail_r <= !(acc_r == WIDTH'(1) || acc_r == top_r);
        ST_SQR: if (mul_ctl.done) begin
          acc_r <= mul_p;
          j_r   <= j_r + CW'(1);
        end
        ST_SQR_CHECK: begin
          if (acc_r == WIDTH'(1)) fail_r <= 1'b1;
          else if (acc_r == top_r) fail_r <= 1'b0;
          else if (j_r >= s_r) fail_r <= 1'b1;
        end
        ST_DONE: begin
          if (!out_stall) begin
            if (last_r) comp_r <= 1'b0;
            else if (fail_r) comp_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  `MRW_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_r != ST_IDLE, !in_ch.ready)
  `MRW_ASSERT_NXT(a_done_to_idle, clk, rst_n, state_r == ST_DONE && !out_stall, state_r == ST_IDLE)
  `MRW_ASSERT_NXT(a_out_only_last, clk, rst_n, state_r == ST_DONE && !last_r, !$rose(out_valid_r))
  `MRW_ASSERT_IMP(a_mul_idle_out, clk, rst_n, state_r == ST_IDLE, !mul_ctl.busy)
endmodule

FILE: rtl/mrw_mulmod.sv
// bit-serial shift-add modular multiplier
module mrw_mulmod #(
  parameter int unsigned WIDTH = mrw_pkg::WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [WIDTH-1:0]   x,
  input  logic [WIDTH-1:0]   y,
  input  logic [WIDTH-1:0]   m,
  output logic [WIDTH-1:0]   prod,
  output mrw_pkg::mrw_mul_ctl_t ctl
);
  import mrw_pkg::*;

  logic [WIDTH-1:0] x_r, y_r, acc_r;
  logic             busy_r, done_r;
  logic [WIDTH:0]   acc_sum, x_dbl, acc_red, x_red;

  assign acc_sum = {1'b0, acc_r} + {1'b0, x_r};
  assign acc_red = (acc_sum >= {1'b0, m}) ? acc_sum - {1'b0, m} : acc_sum;
  assign x_dbl   = {x_r, 1'b0};
  assign x_red   = (x_dbl >= {1'b0, m}) ? x_dbl - {1'b0, m} : x_dbl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        x_r    <= x;
        y_r    <= y;
        acc_r  <= '0;
      end else if (busy_r) begin
        if (y_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          if (y_r[0]) acc_r <= acc_red[WIDTH-1:0];
          x_r <= x_red[WIDTH-1:0];
          y_r <= y_r >> 1;
        end
      end
    end
  end

  assign prod      = acc_r;
  assign ctl.start = start;
  assign ctl.busy  = busy_r;
  assign ctl.done  = done_r;
endmodule
